FILE: src/greedy_edge_cluster_labeler_top_assert.svh
// Assertion macros for the greedy edge cluster labeler.
// Both expect signals named clk and arst_n in the enclosing scope.
`ifndef GREEDY_EDGE_CLUSTER_LABELER_TOP_ASSERT_SVH
`define GREEDY_EDGE_CLUSTER_LABELER_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define GECL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define GECL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/gecl_pkg.sv
// ----------------------------------------------------------------------------
// gecl_pkg
// Types and constants shared by the cluster labeler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gecl_pkg;

	localparam int VID_W   = 10;
	localparam int LABEL_W = 11;
	localparam int CASE_W  = 2;

	typedef logic [LABEL_W-1:0] label_t;
	typedef logic [VID_W-1:0]   vid_t;

	// step case codes
	localparam logic [CASE_W-1:0] CASE_NEW       = 2'd0;
	localparam logic [CASE_W-1:0] CASE_JOIN_FROM = 2'd1;
	localparam logic [CASE_W-1:0] CASE_JOIN_TO   = 2'd2;
	localparam logic [CASE_W-1:0] CASE_NONE      = 2'd3;

	localparam label_t VCOUNT_RESET = 11'd1024;

	typedef struct packed {
		logic clr;     // clearing pass, write zero at sweep address
		logic accept;  // capture request, start label reads
		logic eval;    // labels available, decide and write first label
		logic wr2;     // write second label of a new cluster
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic need_wr2;
	} dp_status_t;

	typedef struct packed {
		label_t            from_label;
		label_t            to_label;
		logic [CASE_W-1:0] step_case;
		label_t            assigned_total;
		logic              all_assigned;
		logic              vertex_error;
	} result_t;

endpackage

`default_nettype wire

FILE: src/gecl_ram.sv
// ----------------------------------------------------------------------------
// gecl_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gecl_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

FILE: src/gecl_ctrl.sv
// ----------------------------------------------------------------------------
// gecl_ctrl
// Sequencer: clearing pass, request accept, evaluate, second write, result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module gecl_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output gecl_pkg::dp_cmd_t          cmd,
	input  wire gecl_pkg::dp_status_t  status
);
	import gecl_pkg::*;

	typedef enum logic [1:0] {
		S_CLR,
		S_IDLE,
		S_EVAL,
		S_WR2
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// a new request only when the result register is free by the next edge
	assign s_tready   = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign m_tvalid   = out_valid_q;

	assign cmd.clr    = (state_q == S_CLR);
	assign cmd.accept = s_tvalid && s_tready;
	assign cmd.eval   = (state_q == S_EVAL);
	assign cmd.wr2    = (state_q == S_WR2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (status.clr_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd.accept) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (status.need_wr2) begin
						state_q <= S_WR2;
					end else begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				S_WR2: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: begin
					state_q <= S_CLR;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/gecl_datapath.sv
// ----------------------------------------------------------------------------
// gecl_datapath
// Label store, cluster and assigned counters, case decision, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gecl_datapath #(
	parameter int MAX_VERTICES = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire gecl_pkg::dp_cmd_t     cmd,
	output gecl_pkg::dp_status_t       status,
	input  wire gecl_pkg::vid_t        in_from_vertex,
	input  wire gecl_pkg::vid_t        in_to_vertex,
	input  wire logic                  cfg_wr_en,
	input  wire gecl_pkg::label_t      cfg_wr_data,
	output gecl_pkg::result_t          result
);
	import gecl_pkg::*;

	// ids are VID_W bits wide, so no more entries than that are reachable
	localparam int ID_SPAN = 2 ** VID_W;
	localparam int DEPTH   = (MAX_VERTICES > ID_SPAN) ? ID_SPAN : MAX_VERTICES;
	localparam int AW      = $clog2(DEPTH);

	vid_t             from_q;
	vid_t             to_q;
	logic             err_q;
	label_t           vcount_q;
	label_t           next_cluster_q;
	label_t           assigned_q;
	label_t           new_label_q;
	logic [AW-1:0]    clr_addr_q;
	result_t          res_q;

	label_t           fa;
	label_t           fb;
	logic             in_err;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	label_t           wr_data;

	logic             ev_wr_en;
	logic [AW-1:0]    ev_wr_addr;
	label_t           ev_wr_data;
	logic [CASE_W-1:0] ev_case;
	label_t           ev_la;
	label_t           ev_lb;
	label_t           ev_add;
	label_t           assigned_nxt;

	assign in_err = !((LABEL_W'(in_from_vertex) < LABEL_W'(DEPTH))
		&& (LABEL_W'(in_from_vertex) < vcount_q)
		&& (LABEL_W'(in_to_vertex) < LABEL_W'(DEPTH))
		&& (LABEL_W'(in_to_vertex) < vcount_q));

	// duplicated store: one copy per read address, both written alike
	gecl_ram #(.WIDTH(LABEL_W), .DEPTH(DEPTH)) u_ram_from (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (in_from_vertex[AW-1:0]),
		.rd_data (fa)
	);

	gecl_ram #(.WIDTH(LABEL_W), .DEPTH(DEPTH)) u_ram_to (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (in_to_vertex[AW-1:0]),
		.rd_data (fb)
	);

	always_comb begin
		ev_wr_en   = 1'b0;
		ev_wr_addr = from_q[AW-1:0];
		ev_wr_data = next_cluster_q;
		ev_case    = CASE_NONE;
		ev_la      = fa;
		ev_lb      = fb;
		ev_add     = '0;
		priority if (err_q) begin
			ev_la = '0;
			ev_lb = '0;
		end else if (fa == '0 && fb == '0) begin
			ev_wr_en = 1'b1;
			ev_case  = CASE_NEW;
			ev_la    = next_cluster_q;
			ev_lb    = next_cluster_q;
			ev_add   = (from_q == to_q) ? LABEL_W'(1) : LABEL_W'(2);
		end else if (fb == '0) begin
			ev_wr_en   = 1'b1;
			ev_wr_addr = to_q[AW-1:0];
			ev_wr_data = fa;
			ev_case    = CASE_JOIN_FROM;
			ev_lb      = fa;
			ev_add     = LABEL_W'(1);
		end else if (fa == '0) begin
			ev_wr_en   = 1'b1;
			ev_wr_data = fb;
			ev_case    = CASE_JOIN_TO;
			ev_la      = fb;
			ev_add     = LABEL_W'(1);
		end else begin
			ev_case = CASE_NONE;
		end
	end

	assign assigned_nxt = assigned_q + ev_add;

	always_comb begin
		priority if (cmd.clr) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else if (cmd.wr2) begin
			wr_en   = 1'b1;
			wr_addr = to_q[AW-1:0];
			wr_data = new_label_q;
		end else begin
			wr_en   = cmd.eval && ev_wr_en;
			wr_addr = ev_wr_addr;
			wr_data = ev_wr_data;
		end
	end

	assign status.clr_done = (clr_addr_q == AW'(DEPTH - 1));
	assign status.need_wr2 = cmd.eval && !err_q && (ev_case == CASE_NEW) && (from_q != to_q);
	assign result          = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q       <= VCOUNT_RESET;
			next_cluster_q <= LABEL_W'(1);
			assigned_q     <= '0;
			clr_addr_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				vcount_q <= cfg_wr_data;
			end
			if (cmd.clr && !status.clr_done) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cmd.eval) begin
				assigned_q <= assigned_nxt;
				if (!err_q && ev_case == CASE_NEW) begin
					next_cluster_q <= next_cluster_q + LABEL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			from_q <= in_from_vertex;
			to_q   <= in_to_vertex;
			err_q  <= in_err;
		end
		if (cmd.eval) begin
			new_label_q          <= next_cluster_q;
			res_q.from_label     <= ev_la;
			res_q.to_label       <= ev_lb;
			res_q.step_case      <= ev_case;
			res_q.assigned_total <= assigned_nxt;
			res_q.all_assigned   <= (assigned_nxt >= vcount_q);
			res_q.vertex_error   <= err_q;
		end
	end

endmodule

`default_nettype wire

FILE: src/greedy_edge_cluster_labeler_top.sv
// ----------------------------------------------------------------------------
// greedy_edge_cluster_labeler_top
// Greedy cluster labeling of a stream of sorted graph edges.
// ----------------------------------------------------------------------------
// Each edge request on s_* yields one result on m_*. An edge is accepted,
// then evaluated with both labels read from two copies of the label store;
// an edge that opens a new cluster on two distinct vertices then also needs
// a second write, since the second label goes through the single write port.
// A result waiting in the output register does not block the next request
// once m_tready is high. After reset a clearing pass writes zero to the
// min(MAX_VERTICES, 1024) label entries, one per cycle, with s_tready low; the
// vertex_count register may be written at any time outside active requests.
`default_nettype none

`include "greedy_edge_cluster_labeler_top_assert.svh"

module greedy_edge_cluster_labeler_top #(
	parameter int MAX_VERTICES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [9:0] from_vertex, [19:10] to_vertex, [23:20] zero
	input  wire logic [23:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [10:0] from_label, [21:11] to_label, [32:22] assigned_total,
	// [33] all_assigned, [39:34] zero
	output logic [39:0]      m_tdata,
	// [1:0] step_case, [2] vertex_error
	output logic [2:0]       m_tuser,
	input  wire logic        cfg_wr_en,
	input  wire logic [10:0] cfg_wr_data
);
	import gecl_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	result_t    result;

	gecl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	gecl_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_from_vertex (s_tdata[9:0]),
		.in_to_vertex   (s_tdata[19:10]),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.result         (result)
	);

	assign m_tdata = {6'b0, result.all_assigned, result.assigned_total,
		result.to_label, result.from_label};
	assign m_tuser = {result.vertex_error, result.step_case};

	`GECL_ASSERT_SAME(a_no_accept_over_result, s_tvalid && s_tready, !m_tvalid || m_tready, "request accepted while result stalled")
	`GECL_ASSERT_NEXT(a_accept_then_eval, s_tvalid && s_tready, cmd.eval, "accept not followed by evaluate")
	`GECL_ASSERT_SAME(a_valid_after_work, $rose(m_tvalid), $past(cmd.eval) || $past(cmd.wr2), "result valid without work")
	`GECL_ASSERT_SAME(a_no_ready_in_clear, cmd.clr, !s_tready, "ready during clearing pass")

endmodule

`default_nettype wire
